// ----- rtl/core/ccde_pkg.sv -----
// Shared types and constants for the character canvas draw engine.
package ccde_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;
    localparam int CFG_W        = 9;
    localparam int COORD_W      = 11;
    localparam int RAD_W        = 10;
    localparam int GLYPH_W      = 8;
    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd32;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd64;

    typedef enum logic [2:0] {
        KIND_CLEAR = 3'd0,
        KIND_POINT = 3'd1,
        KIND_LINE  = 3'd2,
        KIND_RECT  = 3'd3,
        KIND_FILL  = 3'd4,
        KIND_RING  = 3'd5,
        KIND_DISC  = 3'd6,
        KIND_READ  = 3'd7
    } kind_t;

    typedef enum logic [0:0] {
        CFG_HEIGHT = 1'b0,
        CFG_WIDTH  = 1'b1
    } cfg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the request
        logic init_pt;   // start walk at (row_a,col_a) or scan/sweep origin
        logic step;      // advance walk one cell, write if hit
        logic rd_issue;  // issue the read-back address
        logic clr_mode;  // sweep whole store (reset clearing pass)
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;      // walk reached its last cell this step
        kind_t kind;
    } dp_sts_t;

endpackage

// ----- rtl/core/ccde_datapath.sv -----
// Datapath: request registers, cell walkers, shape tests and frame store.
module ccde_datapath #(
    parameter int MAX_ROWS = ccde_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = ccde_pkg::MAX_COLS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ccde_pkg::dp_cmd_t            cmd,
    output ccde_pkg::dp_sts_t            sts,
    input  logic [2:0]                   in_kind,
    input  logic signed [10:0]           in_row_a,
    input  logic signed [10:0]           in_col_a,
    input  logic signed [10:0]           in_row_b,
    input  logic signed [10:0]           in_col_b,
    input  logic [9:0]                   in_radius,
    input  logic [7:0]                   in_glyph,
    input  logic                         cfg_we,
    input  logic                         cfg_idx,
    input  logic [8:0]                   cfg_data,
    output logic [7:0]                   rd_data
);
    import ccde_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    // store is addressed by {row, col}, so it spans the full power-of-two field
    localparam int DEPTH = 1 << (RW + CW);
    localparam int SW    = 12; // signed walker width, holds -2048..2047

    logic [CFG_W-1:0] height_reg, width_reg;
    kind_t kind_reg;
    logic signed [SW-1:0] ra_reg, ca_reg, rb_reg, cb_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [7:0] glyph_reg;

    // walker position
    logic signed [SW-1:0] r_reg, r_next, c_reg, c_next;
    // Bresenham terms
    logic signed [SW+1:0] err_reg, err_next, dr_reg, dc_reg;
    logic signed [1:0] sr_reg, sc_reg;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    logic signed [SW-1:0] h_eff, w_eff;
    logic [CFG_W-1:0] h_cl, w_cl;

    always_comb begin
        h_cl = (height_reg == '0) ? CFG_W'(1) : height_reg;
        if (32'(h_cl) > MAX_ROWS) h_cl = CFG_W'(MAX_ROWS);
        w_cl = (width_reg == '0) ? CFG_W'(1) : width_reg;
        if (32'(w_cl) > MAX_COLS) w_cl = CFG_W'(MAX_COLS);
        h_eff = SW'({1'b0, h_cl});
        w_eff = SW'({1'b0, w_cl});
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_RST;
            width_reg  <= WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // squared distance, one multiplier per axis, feeds the shape test
    logic signed [SW:0] dr_c, dc_c;
    logic [23:0] dd;
    logic [21:0] rr;
    logic [21:0] rr_lo, rr_hi;
    assign dr_c = {r_reg[SW-1], r_reg} - {ra_reg[SW-1], ra_reg};
    assign dc_c = {c_reg[SW-1], c_reg} - {ca_reg[SW-1], ca_reg};
    logic [SW-1:0] adr, adc;
    assign adr = dr_c[SW] ? SW'(-dr_c) : SW'(dr_c);
    assign adc = dc_c[SW] ? SW'(-dc_c) : SW'(dc_c);
    assign dd  = 24'(adr) * 24'(adr) + 24'(adc) * 24'(adc);
    assign rr  = 22'(rad_reg) * 22'(rad_reg);
    assign rr_lo = rr - 22'(rad_reg);
    assign rr_hi = rr + 22'(rad_reg);

    logic hit, in_canvas;
    always_comb begin
        in_canvas = (r_reg >= 0) && (c_reg >= 0) && (r_reg < h_eff) && (c_reg < w_eff);
        case (kind_reg) inside
            KIND_CLEAR, KIND_POINT, KIND_LINE: hit = 1'b1;
            KIND_RECT: hit = ((r_reg == ra_reg || r_reg == rb_reg) &&
                              c_reg >= ca_reg && c_reg <= cb_reg) ||
                             ((c_reg == ca_reg || c_reg == cb_reg) &&
                              r_reg >= ra_reg && r_reg <= rb_reg);
            KIND_FILL: hit = r_reg > ra_reg && r_reg < rb_reg &&
                             c_reg > ca_reg && c_reg < cb_reg;
            KIND_RING: hit = dd >= 24'(rr_lo) && dd <= 24'(rr_hi);
            KIND_DISC: hit = dd <= 24'(rr);
            default:   hit = 1'b0;
        endcase
        if (cmd.clr_mode) in_canvas = 1'b1;
    end

    // kinds that sweep the whole canvas; point, line and read start at (row_a,col_a)
    logic scan_kind;
    assign scan_kind = kind_reg != KIND_POINT && kind_reg != KIND_LINE &&
                       kind_reg != KIND_READ;

    logic signed [SW+2:0] e2;
    logic scan_last;
    always_comb begin
        e2 = {err_reg[SW+1], err_reg} <<< 1;
        r_next = r_reg;
        c_next = c_reg;
        err_next = err_reg;
        if (cmd.clr_mode) begin
            scan_last = (r_reg == SW'(MAX_ROWS - 1)) && (c_reg == SW'(MAX_COLS - 1));
        end else begin
            scan_last = (r_reg == h_eff - 1) && (c_reg == w_eff - 1);
        end
        if (cmd.clr_mode || scan_kind) begin
            if ((cmd.clr_mode && c_reg == SW'(MAX_COLS - 1)) ||
                (!cmd.clr_mode && c_reg == w_eff - 1)) begin
                c_next = '0;
                r_next = r_reg + SW'(1);
            end else begin
                c_next = c_reg + SW'(1);
            end
        end else begin
            if (e2 > -(SW+3)'(dr_reg)) begin
                err_next = err_next - dr_reg;
                c_next = c_reg + SW'(sc_reg);
            end
            if (e2 < (SW+3)'(dc_reg)) begin
                err_next = err_next + dc_reg;
                r_next = r_reg + SW'(sr_reg);
            end
        end
    end

    always_comb begin
        sts.kind = kind_reg;
        if (cmd.clr_mode || scan_kind) sts.done = scan_last;
        else if (kind_reg == KIND_POINT) sts.done = 1'b1;
        else sts.done = (r_reg == rb_reg) && (c_reg == cb_reg);
    end

    logic signed [SW-1:0] dcl, drl;
    assign dcl = (cb_reg > ca_reg) ? cb_reg - ca_reg : ca_reg - cb_reg;
    assign drl = (rb_reg > ra_reg) ? rb_reg - ra_reg : ra_reg - rb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind_t'(in_kind);
            ra_reg    <= SW'(in_row_a);
            ca_reg    <= SW'(in_col_a);
            rb_reg    <= SW'(in_row_b);
            cb_reg    <= SW'(in_col_b);
            rad_reg   <= in_radius;
            glyph_reg <= in_glyph;
        end
        if (cmd.init_pt) begin
            if (cmd.clr_mode || scan_kind) begin
                r_reg <= '0;
                c_reg <= '0;
            end else begin
                r_reg <= ra_reg;
                c_reg <= ca_reg;
            end
            dc_reg  <= (SW+2)'(dcl);
            dr_reg  <= (SW+2)'(drl);
            err_reg <= (SW+2)'(dcl) - (SW+2)'(drl);
            sc_reg  <= (ca_reg < cb_reg) ? 2'sd1 : -2'sd1;
            sr_reg  <= (ra_reg < rb_reg) ? 2'sd1 : -2'sd1;
        end else if (cmd.step) begin
            r_reg   <= r_next;
            c_reg   <= c_next;
            err_reg <= err_next;
        end
    end

    logic [RW+CW-1:0] addr;
    assign addr = {r_reg[RW-1:0], c_reg[CW-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.step && in_canvas && (cmd.clr_mode || hit))
            mem[addr] <= (cmd.clr_mode || kind_reg == KIND_CLEAR) ? SPACE_CODE : glyph_reg;
        if (cmd.rd_issue)
            rd_data_reg <= mem[addr];
    end

    logic rd_ok_reg;
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) rd_ok_reg <= in_canvas;
    end
    assign rd_data = rd_ok_reg ? rd_data_reg : 8'd0;

endmodule

// ----- rtl/core/ccde_ctrl.sv -----
// Controller: sequences clearing pass, command walks and result output.
module ccde_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_read,
    output ccde_pkg::dp_cmd_t cmd,
    input  ccde_pkg::dp_sts_t sts
);
    import ccde_pkg::*;

    typedef enum logic [2:0] {
        ST_CLR_INIT, ST_CLR, ST_IDLE, ST_INIT, ST_WALK, ST_RD, ST_RD2
    } state_t;

    state_t state_reg;
    logic   m_valid_reg, is_read_reg;

    assign s_ready   = state_reg == ST_IDLE && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_is_read = is_read_reg;

    always_comb begin
        cmd = '0;
        cmd.load     = s_valid && s_ready;
        cmd.clr_mode = state_reg == ST_CLR_INIT || state_reg == ST_CLR;
        cmd.init_pt  = state_reg == ST_CLR_INIT || state_reg == ST_INIT;
        cmd.step     = state_reg == ST_CLR || state_reg == ST_WALK;
        cmd.rd_issue = state_reg == ST_RD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR_INIT;
            m_valid_reg <= 1'b0;
            is_read_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLR_INIT: state_reg <= ST_CLR;
                ST_CLR:  if (sts.done) state_reg <= ST_IDLE;
                ST_IDLE: if (s_valid && s_ready) state_reg <= ST_INIT;
                ST_INIT: state_reg <= (sts.kind == KIND_READ) ? ST_RD : ST_WALK;
                ST_WALK: if (sts.done) begin
                    state_reg   <= ST_IDLE;
                    m_valid_reg <= 1'b1;
                    is_read_reg <= 1'b0;
                end
                ST_RD:  state_reg <= ST_RD2;
                ST_RD2: begin
                    state_reg   <= ST_IDLE;
                    m_valid_reg <= 1'b1;
                    is_read_reg <= 1'b1;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/character_canvas_draw_engine_core.sv -----
// Top level of the character canvas draw engine.
//
// channel   dir  tdata (low bit up)                                   tuser
// s_axis    in   row_a[10:0] col_a[21:11] row_b[32:22] col_b[43:33]    kind[2:0]
//                radius[53:44] glyph[61:54], zero pad to 64
// m_axis    out  cell_value[7:0]                                       is_read
//
// Point and read touch one cell; a line walks from (row_a,col_a) to (row_b,col_b);
// other kinds scan the whole canvas at one cell per cycle through the single
// store write port. After reset a clearing pass over all MAX_ROWS*MAX_COLS cells
// fills the store with spaces; no request is taken until it ends. A result waits
// in the output register; the next request is taken once it has been taken.
module character_canvas_draw_engine_core #(
    parameter int MAX_ROWS = ccde_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = ccde_pkg::MAX_COLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // row_a, col_a, row_b, col_b, radius, glyph
    input  logic [2:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // cell_value
    output logic        m_axis_tuser,   // is_read
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [8:0]  cfg_data
);
    import ccde_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    is_read;
    logic [7:0] rd_data;

    ccde_ctrl u_ctrl (
        .aclk, .aresetn,
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_is_read(is_read), .cmd, .sts
    );

    ccde_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_kind(s_axis_tuser),
        .in_row_a(s_axis_tdata[10:0]),
        .in_col_a(s_axis_tdata[21:11]),
        .in_row_b(s_axis_tdata[32:22]),
        .in_col_b(s_axis_tdata[43:33]),
        .in_radius(s_axis_tdata[53:44]),
        .in_glyph(s_axis_tdata[61:54]),
        .cfg_we, .cfg_idx, .cfg_data, .rd_data
    );

    assign m_axis_tuser = is_read;
    assign m_axis_tdata = is_read ? rd_data : 8'd0;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the character canvas draw engine core.
module testbench;
    import ccde_pkg::*;

    localparam int STORE_COLS = 256;

    typedef struct {
        kind_t       kind;
        int          ra, ca, rb, cb;
        int          rad;
        logic [7:0]  glyph;
    } draw_req_t;

    typedef struct {
        logic [7:0] cell_val;
        logic       rd;
    } draw_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // row_a, col_a, row_b, col_b, radius, glyph
    logic [2:0]  s_axis_tuser = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // cell_value
    logic        m_axis_tuser;         // is_read
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [8:0]  cfg_data = '0;

    // shadow of the store and the canvas registers
    logic [7:0]   shadow_store [0:65535];
    logic [8:0]   shadow_height = HEIGHT_RST;
    logic [8:0]   shadow_width  = WIDTH_RST;
    draw_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_request = 0;
    int error_count = 0;
    int checked_count = 0;
    int kind_count [8];

    character_canvas_draw_engine_core uut (.*);

    always #1 aclk = ~aclk;

    // result sink: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        draw_result_t exp_res;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            checked_count++;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected result cell=%0d rd=%0b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata !== exp_res.cell_val || m_axis_tuser !== exp_res.rd) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: result mismatch exp cell=%0d rd=%0b got cell=%0d rd=%0b",
                                 exp_res.cell_val, exp_res.rd, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    function automatic int rows_in_use();
        return (shadow_height == 0) ? 1 : (shadow_height > 256) ? 256 : int'(shadow_height);
    endfunction

    function automatic int cols_in_use();
        return (shadow_width == 0) ? 1 : (shadow_width > 256) ? 256 : int'(shadow_width);
    endfunction

    function automatic bit on_canvas(int r, int c);
        return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
    endfunction

    function automatic void plot_cell(int r, int c, logic [7:0] g);
        if (on_canvas(r, c))
            shadow_store[r * STORE_COLS + c] = g;
    endfunction

    function automatic bit shape_covers(draw_req_t q, int r, int c);
        longint dr, dc, d, rad;
        dr = r - q.ra;
        dc = c - q.ca;
        d = dr * dr + dc * dc;
        rad = q.rad;
        case (q.kind)
            KIND_CLEAR: return 1'b1;
            KIND_RECT: return ((r == q.ra || r == q.rb) && c >= q.ca && c <= q.cb) ||
                              ((c == q.ca || c == q.cb) && r >= q.ra && r <= q.rb);
            KIND_FILL: return r > q.ra && r < q.rb && c > q.ca && c < q.cb;
            KIND_RING: return d >= rad * (rad - 1) && d <= rad * (rad + 1);
            KIND_DISC: return d <= rad * rad;
            default: return 1'b0;
        endcase
    endfunction

    // apply one request to the shadow store and give its result
    function automatic draw_result_t predict_draw(draw_req_t q);
        draw_result_t res;
        int r0, c0, dr, dc, sr, sc, err, e2;
        logic [7:0] v;
        res.cell_val = 8'd0;
        res.rd = 1'b0;
        case (q.kind)
            KIND_POINT: plot_cell(q.ra, q.ca, q.glyph);
            KIND_LINE: begin
                r0 = q.ra;
                c0 = q.ca;
                dc = (q.cb > c0) ? q.cb - c0 : c0 - q.cb;
                dr = (q.rb > r0) ? q.rb - r0 : r0 - q.rb;
                sc = (c0 < q.cb) ? 1 : -1;
                sr = (r0 < q.rb) ? 1 : -1;
                err = dc - dr;
                forever begin
                    plot_cell(r0, c0, q.glyph);
                    if (r0 == q.rb && c0 == q.cb) break;
                    e2 = 2 * err;
                    if (e2 > -dr) begin
                        err -= dr;
                        c0 += sc;
                    end
                    if (e2 < dc) begin
                        err += dc;
                        r0 += sr;
                    end
                end
            end
            KIND_READ: begin
                if (on_canvas(q.ra, q.ca))
                    res.cell_val = shadow_store[q.ra * STORE_COLS + q.ca];
                res.rd = 1'b1;
            end
            default: begin
                v = (q.kind == KIND_CLEAR) ? SPACE_CODE : q.glyph;
                for (int r = 0; r < rows_in_use(); r++)
                    for (int c = 0; c < cols_in_use(); c++)
                        if (shape_covers(q, r, c))
                            shadow_store[r * STORE_COLS + c] = v;
            end
        endcase
        return res;
    endfunction

    // offer one request; valid stays high afterwards until the next call or a drain
    task automatic send_request(draw_req_t q);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= q.kind;
        s_axis_tdata <= {2'b00, q.glyph, 10'(q.rad), 11'(q.cb), 11'(q.rb),
                         11'(q.ca), 11'(q.ra)};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        kind_count[q.kind]++;
        pending_results.push_back(predict_draw(q));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_canvas(logic [8:0] h, logic [8:0] w);
        drain_results();
        cfg_we <= 1'b1;
        cfg_idx <= CFG_HEIGHT;
        cfg_data <= h;
        @(posedge aclk);
        cfg_idx <= CFG_WIDTH;
        cfg_data <= w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_height = h;
        shadow_width = w;
        @(posedge aclk);
    endtask

    task automatic send_cmd(kind_t k, int ra, int ca, int rb, int cb, int rad,
                            logic [7:0] g);
        draw_req_t q;
        q.kind = k;
        q.ra = ra;
        q.ca = ca;
        q.rb = rb;
        q.cb = cb;
        q.rad = rad;
        q.glyph = g;
        send_request(q);
    endtask

    function automatic int pick_coord(int span);
        if ($urandom_range(99) < 85)
            return int'($urandom_range(span + 5)) - 3;
        return int'($urandom_range(2047)) - 1024;
    endfunction

    function automatic draw_req_t random_request();
        draw_req_t q;
        int p;
        p = $urandom_range(99);
        q.kind = (p < 35) ? KIND_READ : (p < 50) ? KIND_POINT : (p < 65) ? KIND_LINE :
                 (p < 73) ? KIND_RECT : (p < 81) ? KIND_FILL : (p < 88) ? KIND_RING :
                 (p < 95) ? KIND_DISC : KIND_CLEAR;
        q.ra = pick_coord(rows_in_use());
        q.ca = pick_coord(cols_in_use());
        q.rb = pick_coord(rows_in_use());
        q.cb = pick_coord(cols_in_use());
        q.rad = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(12);
        q.glyph = $urandom_range(255);
        return q;
    endfunction

    task automatic test_directed();
        send_cmd(KIND_READ, 0, 0, 0, 0, 0, 8'h00);
        send_cmd(KIND_POINT, 0, 0, 0, 0, 0, 8'hFF);
        send_cmd(KIND_POINT, -1, 5, 0, 0, 0, 8'h41);
        send_cmd(KIND_POINT, 31, 63, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 31, 63, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 0, 0, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, -1024, -1024, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 1023, 1023, 0, 0, 0, 8'h00);
        send_cmd(KIND_LINE, -1024, -1024, 1023, 1023, 1023, 8'h2A);
        send_cmd(KIND_LINE, 20, 5, 20, 5, 0, 8'h2B);
        send_cmd(KIND_LINE, 30, 10, 2, 3, 0, 8'h2D);
        send_cmd(KIND_RECT, 2, 3, 10, 20, 0, 8'h23);
        send_cmd(KIND_RECT, 12, 40, 4, 30, 0, 8'h24);
        send_cmd(KIND_FILL, 5, 5, 6, 6, 0, 8'h25);
        send_cmd(KIND_FILL, 1, 40, 9, 60, 0, 8'h26);
        send_cmd(KIND_RING, 16, 32, 0, 0, 0, 8'h6F);
        send_cmd(KIND_RING, 16, 32, 0, 0, 9, 8'h6F);
        send_cmd(KIND_DISC, 3, 3, 0, 0, 0, 8'h40);
        send_cmd(KIND_READ, 3, 3, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 25, 32, 0, 0, 0, 8'h00);
        send_cmd(KIND_DISC, -1024, 1023, 0, 0, 1023, 8'h58);
        send_cmd(KIND_READ, 16, 16, 0, 0, 0, 8'h00);
        send_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 16, 16, 0, 0, 0, 8'h00);
    endtask

    task automatic test_canvas_limits();
        set_canvas(9'd0, 9'd0);
        send_cmd(KIND_POINT, 0, 0, 0, 0, 0, 8'h31);
        send_cmd(KIND_POINT, 0, 1, 0, 0, 0, 8'h32);
        send_cmd(KIND_READ, 0, 0, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 1, 0, 0, 0, 0, 8'h00);
        set_canvas(9'd511, 9'd511);
        send_cmd(KIND_READ, 0, 1, 0, 0, 0, 8'h00);
        send_cmd(KIND_DISC, 255, 255, 0, 0, 2, 8'h7E);
        send_cmd(KIND_READ, 255, 255, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 256, 255, 0, 0, 0, 8'h00);
        set_canvas(9'd256, 9'd1);
        send_cmd(KIND_LINE, -5, 0, 300, 0, 0, 8'h7C);
        send_cmd(KIND_READ, 255, 0, 0, 0, 0, 8'h00);
        send_cmd(KIND_READ, 5, 1, 0, 0, 0, 8'h00);
    endtask

    task automatic test_random_phase(int h, int w, int n);
        set_canvas(9'(h), 9'(w));
        repeat (n) send_request(random_request());
    endtask

    task automatic test_backpressure();
        set_canvas(9'd6, 9'd10);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1;
        repeat (8) send_request(random_request());
        drain_results();
        repeat (6) send_request(random_request());
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 65536; i++) shadow_store[i] = SPACE_CODE;

        test_directed();
        test_canvas_limits();
        test_random_phase(8, 12, 20);
        send_idle_pct = 85;
        test_random_phase(5, 16, 22);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        test_random_phase(16, 3, 22);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        test_random_phase(1, 7, 10);
        test_random_phase(12, 12, 15);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain_results();
        repeat (50) @(posedge aclk);

        $display("Covered %0d results: clear %0d point %0d line %0d rect %0d fill %0d",
                 checked_count, kind_count[0], kind_count[1], kind_count[2],
                 kind_count[3], kind_count[4]);
        $display("ring %0d disc %0d read %0d, canvas sizes 1x1 to 256x256, idle and stall mixes",
                 kind_count[5], kind_count[6], kind_count[7]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Timeout with %0d requests outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ccde_pkg.sv
rtl/core/ccde_datapath.sv
rtl/core/ccde_ctrl.sv
rtl/core/character_canvas_draw_engine_core.sv
verif/testbench.sv
